@@ hw/rtl/dda_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dda_pkg - shared constants and types for the DDA line rasterizer
// Coordinate and fixed-point widths, action codes, divider interface structs.
// ----------------------------------------------------------------------------
package dda_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;

   localparam int ACC_W     = COORD_BITS + FRAC_BITS;  // accumulator
   localparam int INC_W     = FRAC_BITS + 2;           // signed increment
   localparam int QUO_W     = FRAC_BITS + 1;           // |span|*2^F/len <= 2^F
   localparam int MAG_W     = COORD_BITS;              // |span|, length
   localparam int CNT_W     = COORD_BITS + 1;          // points left
   localparam int DIV_CNT_W = $clog2(QUO_W + 1);

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] dividend;
      logic [MAG_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

@@ hw/rtl/dda_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dda_div - radix-2 restoring divider
// Computes (dividend << FRAC_BITS) / divisor for dividend <= divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dda_div (
   input  wire                       clock,
   input  wire                       reset,
   input  wire dda_pkg::div_cmd_type cmd,
   output dda_pkg::div_rsp_type      rsp
);

   logic [dda_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [dda_pkg::MAG_W:0]       rem_ff, rem_in;
   logic [dda_pkg::MAG_W-1:0]     dvs_ff, dvs_in;
   logic [dda_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic                          done_ff, done_in;
   logic                          busy;
   logic                          ge;
   logic [dda_pkg::MAG_W:0]       rem_sub;

   assign busy    = (cnt_ff != '0);
   assign ge      = (rem_ff >= {1'b0, dvs_ff});
   // remainder stays below the divisor, so the doubled value fits
   assign rem_sub = ge ? (rem_ff - {1'b0, dvs_ff}) : rem_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      done_in = busy && (cnt_ff == dda_pkg::DIV_CNT_W'(1));
      if (cmd.start) begin
         cnt_in = dda_pkg::DIV_CNT_W'(dda_pkg::QUO_W);
         rem_in = {1'b0, cmd.dividend};
         dvs_in = cmd.divisor;
         quo_in = '0;
      end else if (busy) begin
         cnt_in = cnt_ff - dda_pkg::DIV_CNT_W'(1);
         rem_in = {rem_sub[dda_pkg::MAG_W-1:0], 1'b0};
         quo_in = {quo_ff[dda_pkg::QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy     = busy;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy)
      else $error("divider started while busy");

   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (quo_ff <= (dda_pkg::QUO_W'(1) << dda_pkg::FRAC_BITS)))
      else $error("quotient exceeds one");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy) && !busy))
      else $error("done without a finished run");

endmodule
`default_nettype wire

@@ hw/rtl/dda_line_rasterizer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dda_line_rasterizer - DDA line point generator
// Load transactions set up a line; step transactions return one point each.
// ----------------------------------------------------------------------------
// Step: point registered on acceptance and shown the next cycle;
//   one step per cycle while the output is taken.
// Load: req_tready low while the shared divider runs the quotient bits
//   and a result for the x increment, then the same for y.
// Either kind waits while a point sits in the output register untaken.
// Reset (synchronous, active high) clears the line state and the output.
module dda_line_rasterizer (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,  // x_start[11:0], y_start, x_end, y_end
   input  wire         req_tuser,  // action
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,  // point_x[11:0], point_y
   output logic        rsp_tlast   // last
);

   localparam int CB = dda_pkg::COORD_BITS;
   localparam int FB = dda_pkg::FRAC_BITS;
   localparam int AW = dda_pkg::ACC_W;
   localparam int IW = dda_pkg::INC_W;
   localparam int MW = dda_pkg::MAG_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DIV_X = 3'b010,
      ST_DIV_Y = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic signed [AW-1:0]          x_acc_ff, x_acc_in, y_acc_ff, y_acc_in;
   logic signed [IW-1:0]          x_inc_ff, x_inc_in, y_inc_ff, y_inc_in;
   logic [dda_pkg::CNT_W-1:0]     left_ff, left_in;
   logic                          active_ff, active_in;
   logic [MW-1:0]                 len_ff, len_in, dy_mag_ff, dy_mag_in;
   logic                          x_neg_ff, x_neg_in, y_neg_ff, y_neg_in;
   logic                          rvalid_ff, rvalid_in, rlast_ff, rlast_in;
   logic [CB-1:0]                 px_ff, px_in, py_ff, py_in;

   dda_pkg::div_cmd_type          div_cmd;
   dda_pkg::div_rsp_type          div_rsp;

   logic signed [CB-1:0]          xs, ys, xe, ye;
   logic signed [CB:0]            dx, dy;
   logic [CB:0]                   dx_abs, dy_abs;
   logic [MW-1:0]                 dx_mag, dy_mag, len;
   logic                          accept, load, step, emit;
   logic signed [IW-1:0]          quo_pos;
   logic [CB-1:0]                 rx, ry;

   assign xs = req_tdata[CB-1:0];
   assign ys = req_tdata[2*CB-1:CB];
   assign xe = req_tdata[3*CB-1:2*CB];
   assign ye = req_tdata[4*CB-1:3*CB];

   assign dx     = {xe[CB-1], xe} - {xs[CB-1], xs};
   assign dy     = {ye[CB-1], ye} - {ys[CB-1], ys};
   assign dx_abs = dx[CB] ? -dx : dx;
   assign dy_abs = dy[CB] ? -dy : dy;
   assign dx_mag = dx_abs[MW-1:0];
   assign dy_mag = dy_abs[MW-1:0];
   assign len    = (dx_mag > dy_mag) ? dx_mag : dy_mag;

   assign req_tready = (state_ff == ST_IDLE) && (!rvalid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign load       = accept && (req_tuser == dda_pkg::ACT_LOAD);
   assign step       = accept && (req_tuser == dda_pkg::ACT_STEP);
   assign emit       = step && active_ff && (left_ff != '0);

   assign quo_pos = {1'b0, div_rsp.quotient};

   // round half toward zero on magnitude, then restore sign
   function automatic logic [CB-1:0] round_acc(input logic signed [AW-1:0] acc);
      logic [AW-1:0] m;
      logic [CB:0]   w;
      m = acc[AW-1] ? -acc : acc;
      w = {1'b0, m[AW-1:FB]} +
          (CB+1)'(m[FB-1:0] > (FB'(1) << (FB - 1)));
      if (acc[AW-1])
         w = -w;
      return w[CB-1:0];
   endfunction

   assign rx = round_acc(x_acc_ff);
   assign ry = round_acc(y_acc_ff);

   always_comb begin
      state_in  = state_ff;
      x_acc_in  = x_acc_ff;
      y_acc_in  = y_acc_ff;
      x_inc_in  = x_inc_ff;
      y_inc_in  = y_inc_ff;
      left_in   = left_ff;
      active_in = active_ff;
      len_in    = len_ff;
      dy_mag_in = dy_mag_ff;
      x_neg_in  = x_neg_ff;
      y_neg_in  = y_neg_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rlast_in  = rlast_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = dx_mag;
      div_cmd.divisor  = len;

      unique case (state_ff)
         ST_IDLE: begin
            if (load) begin
               x_acc_in  = {xs, {FB{1'b0}}};
               y_acc_in  = {ys, {FB{1'b0}}};
               x_inc_in  = '0;
               y_inc_in  = '0;
               left_in   = {1'b0, len};
               active_in = 1'b0;
               len_in    = len;
               dy_mag_in = dy_mag;
               x_neg_in  = dx[CB];
               y_neg_in  = dy[CB];
               if (len != '0) begin
                  div_cmd.start = 1'b1;
                  state_in      = ST_DIV_X;
               end else begin
                  left_in = '0;
               end
            end else if (emit) begin
               rvalid_in = 1'b1;
               px_in     = rx;
               py_in     = ry;
               x_acc_in  = x_acc_ff + {{(AW-IW){x_inc_ff[IW-1]}}, x_inc_ff};
               y_acc_in  = y_acc_ff + {{(AW-IW){y_inc_ff[IW-1]}}, y_inc_ff};
               left_in   = left_ff - dda_pkg::CNT_W'(1);
               rlast_in  = (left_ff == dda_pkg::CNT_W'(1));
               active_in = (left_ff != dda_pkg::CNT_W'(1));
            end else if (step) begin
               active_in = 1'b0;
            end
         end
         ST_DIV_X: begin
            div_cmd.dividend = dy_mag_ff;
            div_cmd.divisor  = len_ff;
            if (div_rsp.done) begin
               x_inc_in      = x_neg_ff ? -quo_pos : quo_pos;
               div_cmd.start = 1'b1;
               state_in      = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            div_cmd.dividend = dy_mag_ff;
            div_cmd.divisor  = len_ff;
            if (div_rsp.done) begin
               y_inc_in  = y_neg_ff ? -quo_pos : quo_pos;
               active_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         x_acc_ff  <= '0;
         y_acc_ff  <= '0;
         x_inc_ff  <= '0;
         y_inc_ff  <= '0;
         left_ff   <= '0;
         active_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         x_acc_ff  <= x_acc_in;
         y_acc_ff  <= y_acc_in;
         x_inc_ff  <= x_inc_in;
         y_inc_ff  <= y_inc_in;
         left_ff   <= left_in;
         active_ff <= active_in;
         rvalid_ff <= rvalid_in;
      end
      len_ff    <= len_in;
      dy_mag_ff <= dy_mag_in;
      x_neg_ff  <= x_neg_in;
      y_neg_ff  <= y_neg_in;
      rlast_ff  <= rlast_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
   end

   dda_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {py_ff, px_ff};
   assign rsp_tlast  = rlast_ff;

   a_active_has_points: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (left_ff != '0))
      else $error("active line with no points left");

   a_active_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(active_ff) |-> ($past(state_ff) == ST_DIV_Y))
      else $error("line became active outside setup");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      load |=> !active_ff)
      else $error("line active right after load");

   a_div_in_setup: assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> (state_ff != ST_IDLE))
      else $error("divider running while idle");

endmodule
`default_nettype wire
